// ===== sv/rss_pkg.sv =====
// Shared types and constants for the region shape statistics block.
package rss_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_BG_RED       = 3'd0;
  localparam logic [2:0] CFG_BG_GREEN     = 3'd1;
  localparam logic [2:0] CFG_BG_BLUE      = 3'd2;
  localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd3;
  localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd4;
  localparam logic [2:0] CFG_RED_LIMIT    = 3'd5;

  localparam int CFG_DATA_W = 11;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROC,
    ST_XGO,
    ST_XRUN,
    ST_YGO,
    ST_YRUN,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic pix_load;
    logic pix_proc;
    logic div_start;
    logic div_sel;
    logic cap_x;
    logic cap_y;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic frame_end;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

// ===== sv/rss_ifs.sv =====
// Pixel and result channel interfaces.
interface rss_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface rss_res_if;
  logic        valid;
  logic        ready;
  logic [19:0] area;
  logic [19:0] border_count;
  logic [9:0]  centroid_x;
  logic [9:0]  centroid_y;
  logic [9:0]  box_width;
  logic [9:0]  box_height;
  logic        region_found;
  modport source (output valid, area, border_count, centroid_x, centroid_y, box_width,
                  box_height, region_found, input ready);
  modport sink (input valid, area, border_count, centroid_x, centroid_y, box_width,
                box_height, region_found, output ready);
endinterface

// ===== sv/region_shape_statistics.sv =====
// Top level of the region shape statistics block.
//
//  channel  dir  transfer   payload
//  pix      in   per pixel  red, green, blue (raster order)
//  res      out  per frame  area, border_count, centroid_x/y, box_width/height,
//                           region_found
//  cfg      in   per write  cfg_we, cfg_index, cfg_data
//
// Each pixel is handled in the idle state, which reads its column of the row
// store, and then in the process state, which updates window, sums and store.
// The last pixel of a frame is followed by two divisions of QW quotient bits
// each (QW = clog2 of the larger maximum frame dimension) and the result load.
// After reset the row store is cleared word by word, with pix.ready low.
// A waiting result sits in its own register; pixels of the next frame keep
// flowing, and only the next frame end waits for it to be taken.
module region_shape_statistics
  import rss_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rss_pix_if.sink               pix,
  rss_res_if.source             res
);

  cmd_t    cmd;
  status_t sts;

  // sequencer
  rss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix.valid),
    .pix_ready (pix.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // statistics datapath, including result register
  rss_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .red          (pix.red),
    .green        (pix.green),
    .blue         (pix.blue),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (res.valid),
    .out_ready    (res.ready),
    .area         (res.area),
    .border_count (res.border_count),
    .centroid_x   (res.centroid_x),
    .centroid_y   (res.centroid_y),
    .box_width    (res.box_width),
    .box_height   (res.box_height),
    .region_found (res.region_found)
  );

endmodule

// ===== sv/rss_div.sv =====
// Restoring divider, one quotient bit per cycle.
module rss_div #(
  parameter int QW = 10,
  parameter int DW = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DW+QW-1:0] dividend,
  input  logic [DW-1:0]    divisor,
  output logic             done,
  output logic [QW-1:0]    quotient
);

  localparam int CNT_W = $clog2(QW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    rem;
  logic [QW-1:0]    low;
  logic [DW:0]      trial;
  logic             qbit;

  // quotient is known to fit in QW bits, so the top DW bits start below the divisor
  assign trial = {rem, low[QW-1]};
  assign qbit  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[DW+QW-1:QW];
      low <= dividend[QW-1:0];
    end else if (busy) begin
      rem <= qbit ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
      low <= {low[QW-2:0], qbit};
    end
  end

  assign quotient = low;

endmodule

// ===== sv/rss_ctrl.sv =====
// Sequencer: row-store clearing, per-pixel steps, division and result load.
module rss_ctrl
  import rss_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    pix_valid,
  output logic    pix_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (sts.clear_done) state_next = ST_IDLE;
      ST_IDLE:  if (pix_valid) state_next = ST_PROC;
      ST_PROC:  state_next = sts.frame_end ? ST_XGO : ST_IDLE;
      ST_XGO:   state_next = ST_XRUN;
      ST_XRUN:  if (sts.div_done) state_next = ST_YGO;
      ST_YGO:   state_next = ST_YRUN;
      ST_YRUN:  if (sts.div_done) state_next = ST_LOAD;
      ST_LOAD:  if (!sts.out_busy) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    pix_ready = 1'b0;
    unique case (state)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: begin
        pix_ready    = 1'b1;
        cmd.pix_load = pix_valid;
      end
      ST_PROC:  cmd.pix_proc = 1'b1;
      ST_XGO:   cmd.div_start = 1'b1;
      ST_XRUN:  cmd.cap_x = sts.div_done;
      ST_YGO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
      end
      ST_YRUN: begin
        cmd.div_sel = 1'b1;
        cmd.cap_y   = sts.div_done;
      end
      ST_LOAD:  cmd.load_out = !sts.out_busy;
      default:  cmd = '0;
    endcase
  end

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == ST_XRUN || state == ST_YRUN))
    else $error("divider finished outside a division step");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !sts.out_busy)
    else $error("result loaded over an untaken result");

  a_pix_then_proc: assert property (@(posedge clk) disable iff (rst)
    cmd.pix_load |=> state == ST_PROC)
    else $error("accepted pixel not processed");

endmodule

// ===== sv/rss_dp.sv =====
// Datapath: config, counters, row store, window, accumulators, divider, result.
module rss_dp
  import rss_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  input  cmd_t                  cmd,
  output status_t               sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [19:0]           area,
  output logic [19:0]           border_count,
  output logic [9:0]            centroid_x,
  output logic [9:0]            centroid_y,
  output logic [9:0]            box_width,
  output logic [9:0]            box_height,
  output logic                  region_found
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int QW = (CW > RW) ? CW : RW;
  localparam int AW = CW + RW;
  localparam int SW = AW + QW;

  // configuration
  logic [7:0]            bg_red, bg_green, bg_blue, red_limit;
  logic [CFG_DATA_W-1:0] frame_width, frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_red       <= 8'd255;
      bg_green     <= 8'd255;
      bg_blue      <= 8'd255;
      frame_width  <= CFG_DATA_W'(1024);
      frame_height <= CFG_DATA_W'(1024);
      red_limit    <= 8'd210;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BG_RED:       bg_red <= cfg_data[7:0];
        CFG_BG_GREEN:     bg_green <= cfg_data[7:0];
        CFG_BG_BLUE:      bg_blue <= cfg_data[7:0];
        CFG_FRAME_WIDTH:  frame_width <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        CFG_RED_LIMIT:    red_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // last column / row after clamping the frame size
  logic [CW-1:0] last_col_pos;
  logic [RW-1:0] last_row_pos;

  always_comb begin
    if (frame_width < CFG_DATA_W'(2)) last_col_pos = CW'(1);
    else if (32'(frame_width) > 32'(MAX_WIDTH)) last_col_pos = CW'(MAX_WIDTH - 1);
    else last_col_pos = CW'(frame_width - CFG_DATA_W'(1));
    if (frame_height < CFG_DATA_W'(2)) last_row_pos = RW'(1);
    else if (32'(frame_height) > 32'(MAX_HEIGHT)) last_row_pos = RW'(MAX_HEIGHT - 1);
    else last_row_pos = RW'(frame_height - CFG_DATA_W'(1));
  end

  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic          last_col, last_row;

  assign last_col = column_count >= last_col_pos;
  assign last_row = row_count >= last_row_pos;

  // pixel latch
  logic [7:0] pix_r, pix_g, pix_b;
  always_ff @(posedge clk) begin
    if (cmd.pix_load) begin
      pix_r <= red;
      pix_g <= green;
      pix_b <= blue;
    end
  end

  // row store word: [2] red flag bank 0, [1] red flag bank 1, [0] foreground
  logic [2:0]    row_mem [MAX_WIDTH];
  logic [2:0]    mem_rd, mem_wd;
  logic [CW-1:0] mem_wa, clr_addr;
  logic          mem_we;

  logic fg, hot, bank, top, mid;
  assign fg   = (pix_r != bg_red) || (pix_g != bg_green) || (pix_b != bg_blue);
  assign hot  = pix_r > red_limit;
  assign bank = row_count[0];
  assign top  = bank ? mem_rd[1] : mem_rd[2];
  assign mid  = bank ? mem_rd[2] : mem_rd[1];

  always_comb begin
    if (cmd.clear_step) begin
      mem_wa = clr_addr;
      mem_wd = '0;
    end else begin
      mem_wa = column_count;
      mem_wd = bank ? {mem_rd[2], hot, fg} : {hot, mem_rd[1], fg};
    end
  end
  assign mem_we = cmd.clear_step | cmd.pix_proc;

  always_ff @(posedge clk) begin
    if (mem_we) row_mem[mem_wa] <= mem_wd;
    if (cmd.pix_load) mem_rd <= row_mem[column_count];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clear_step) clr_addr <= clr_addr + 1'b1;
  end

  // window and accumulators
  logic [8:0]    window_flags, window_next;
  logic          fg_delayed;
  logic [AW-1:0] area_sum, border_sum;
  logic [SW-1:0] x_sum, y_sum;
  logic [CW-1:0] min_x, max_x;
  logic [RW-1:0] min_y, max_y;
  logic          border_hit, inner;

  assign window_next = {window_flags[5:0], top, mid, hot};
  assign border_hit  = (column_count != '0) && (row_count != '0) &&
                       (column_count <= last_col_pos) && (row_count <= last_row_pos) &&
                       fg_delayed &&
                       ((column_count <= CW'(2)) || (row_count <= RW'(2)) ||
                        (window_next != '0));
  assign inner = !last_col && !last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      window_flags <= '0;
      fg_delayed   <= 1'b0;
      area_sum     <= '0;
      border_sum   <= '0;
      x_sum        <= '0;
      y_sum        <= '0;
      min_x        <= '1;
      max_x        <= '0;
      min_y        <= '1;
      max_y        <= '0;
    end else if (cmd.pix_proc) begin
      window_flags <= window_next;
      fg_delayed   <= mem_rd[0];
      if (border_hit) border_sum <= border_sum + 1'b1;
      if (fg) begin
        if (inner) begin
          area_sum <= area_sum + 1'b1;
          x_sum    <= x_sum + SW'(column_count);
          y_sum    <= y_sum + SW'(row_count);
        end
        if (column_count < min_x) min_x <= column_count;
        if (column_count > max_x) max_x <= column_count;
        if (row_count < min_y) min_y <= row_count;
        if (row_count > max_y) max_y <= row_count;
      end
      if (!last_col) begin
        column_count <= column_count + 1'b1;
      end else begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + 1'b1;
      end
    end else if (cmd.load_out) begin
      area_sum   <= '0;
      border_sum <= '0;
      x_sum      <= '0;
      y_sum      <= '0;
      min_x      <= '1;
      max_x      <= '0;
      min_y      <= '1;
      max_y      <= '0;
    end
  end

  // shared divider: x sum first, then y sum
  logic [QW-1:0] quot, quot_x, quot_y;
  logic          div_done;

  rss_div #(.QW(QW), .DW(AW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cmd.div_sel ? y_sum : x_sum),
    .divisor  (area_sum),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_x) quot_x <= quot;
    if (cmd.cap_y) quot_y <= quot;
  end

  // result register
  logic found;
  assign found = area_sum != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      area         <= 20'(area_sum);
      border_count <= 20'(border_sum);
      region_found <= found;
      centroid_x   <= found ? 10'(quot_x) : '0;
      centroid_y   <= found ? 10'(quot_y) : '0;
      box_width    <= (found && max_x >= min_x) ? 10'(max_x - min_x) : '0;
      box_height   <= (found && max_y >= min_y) ? 10'(max_y - min_y) : '0;
    end
  end

  assign sts.clear_done = clr_addr == CW'(MAX_WIDTH - 1);
  assign sts.frame_end  = last_col && last_row;
  assign sts.div_done   = div_done;
  assign sts.out_busy   = out_valid && !out_ready;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for region_shape_statistics: directed and random frames against a frame predictor.
module tb_top;
  import rss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W      = 1024;
  localparam int MAX_H      = 1024;
  localparam int ITEM_GOAL  = 1350;
  localparam int CYCLE_CAP  = 1000000;
  localparam int SETTLE     = 80;   // division plus result load, with margin

  typedef struct packed {
    logic [19:0] area;
    logic [19:0] border_count;
    logic [9:0]  centroid_x;
    logic [9:0]  centroid_y;
    logic [9:0]  box_width;
    logic [9:0]  box_height;
    logic        region_found;
  } frame_stats_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [2:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rss_pix_if pix ();
  rss_res_if res ();

  region_shape_statistics dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix),
    .res       (res)
  );

  always #5 clk = ~clk;

  // Register mirror, written by the stimulus process only while the block is idle
  logic [7:0]  bg_r = 8'd255, bg_g = 8'd255, bg_b = 8'd255, hot_limit = 8'd210;
  logic [10:0] width_reg = 11'd1024, height_reg = 11'd1024;

  // Frame predictor state
  int unsigned col, row;
  bit          hot_rows [2][MAX_W];
  bit          fg_prev_row [MAX_W];
  logic [8:0]  hot_window;
  bit          fg_centre;
  int unsigned fg_area, border_hits;
  longint unsigned sum_x, sum_y;
  int unsigned lo_x, hi_x, lo_y, hi_y;

  logic [23:0]  pixel_q [$];
  frame_stats_t stats_q [$];
  int           errors;
  int           pixels_queued;
  bit           calm;          // no gaps on either side while set
  bit           press_go;
  int           press_left;
  int           send_gap, recv_gap;
  int           cycles;

  function automatic int unsigned clamp_dim(logic [10:0] v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  task automatic clear_sums();
    fg_area = 0; border_hits = 0; sum_x = 0; sum_y = 0;
    lo_x = 32'hFFFFF; lo_y = 32'hFFFFF; hi_x = 0; hi_y = 0;
  endtask

  // One accepted pixel through the predictor; a frame end queues its statistics
  task automatic predict_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int unsigned  w, h, ix, bank, was_centre;
    bit           fg, hot, top, mid;
    frame_stats_t s;
    w    = clamp_dim(width_reg, MAX_W);
    h    = clamp_dim(height_reg, MAX_H);
    ix   = (col < MAX_W) ? col : MAX_W - 1;
    fg   = (r != bg_r) || (g != bg_g) || (b != bg_b);
    hot  = r > hot_limit;
    bank = row & 1;
    top  = hot_rows[bank][ix];
    mid  = hot_rows[bank ^ 1][ix];
    was_centre = fg_centre;
    hot_rows[bank][ix] = hot;
    hot_window = {hot_window[5:0], top, mid, hot};
    fg_centre = fg_prev_row[ix];
    fg_prev_row[ix] = fg;

    // border verdict lags one row and one column behind the arriving pixel
    if (col >= 1 && row >= 1 && col - 1 <= w - 2 && row - 1 <= h - 2 && was_centre)
      if (col - 1 <= 1 || row - 1 <= 1 || hot_window != 0)
        border_hits = (border_hits + 1) & 32'hFFFFFFF;

    if (fg) begin
      if (col <= w - 2 && row <= h - 2) begin
        fg_area = (fg_area + 1) & 32'hFFFFFFF;
        sum_x += col;
        sum_y += row;
      end
      if (col < lo_x) lo_x = col;
      if (col > hi_x) hi_x = col;
      if (row < lo_y) lo_y = row;
      if (row > hi_y) hi_y = row;
    end

    if (col < w - 1) begin
      col++;
    end else begin
      col = 0;
      if (row < h - 1) begin
        row++;
      end else begin
        row = 0;
        s = '0;
        s.area         = fg_area[19:0];
        s.border_count = border_hits[19:0];
        if (fg_area != 0) begin
          s.centroid_x   = 10'(sum_x / fg_area);
          s.centroid_y   = 10'(sum_y / fg_area);
          s.box_width    = 10'((hi_x >= lo_x) ? hi_x - lo_x : 0);
          s.box_height   = 10'((hi_y >= lo_y) ? hi_y - lo_y : 0);
          s.region_found = 1'b1;
        end
        stats_q.insert(stats_q.size(), s);
        clear_sums();
      end
    end
  endtask

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Pixel driver: predicts on each transfer, then offers the next queued pixel
  always @(posedge clk) begin
    logic [23:0] px;
    if (rst) begin
      pix.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (pix.valid && pix.ready) predict_pixel(pix.red, pix.green, pix.blue);
      if (!pix.valid || pix.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          pix.valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          px = pixel_q.pop_front();
          pix.valid <= 1'b1;
          {pix.red, pix.green, pix.blue} <= px;
          send_gap = pick_gap();
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the block backs up into its input
  always @(posedge clk) begin
    if (press_go) press_left <= 400;
    else if (press_left > 0) press_left <= press_left - 1;
  end

  // Result monitor: each transfer against the oldest predicted frame
  always @(posedge clk) begin
    frame_stats_t want;
    if (rst) begin
      res.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (stats_q.size() == 0) begin
          $display("MISMATCH unexpected result at %0t", $realtime);
          errors++;
        end else begin
          want = stats_q.pop_front();
          if (res.area != want.area) report("area", res.area, want.area);
          if (res.border_count != want.border_count)
            report("border_count", res.border_count, want.border_count);
          if (res.centroid_x != want.centroid_x)
            report("centroid_x", res.centroid_x, want.centroid_x);
          if (res.centroid_y != want.centroid_y)
            report("centroid_y", res.centroid_y, want.centroid_y);
          if (res.box_width != want.box_width)
            report("box_width", res.box_width, want.box_width);
          if (res.box_height != want.box_height)
            report("box_height", res.box_height, want.box_height);
          if (res.region_found != want.region_found)
            report("region_found", res.region_found, want.region_found);
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        res.ready <= 1'b0;
      end else begin
        recv_gap = pick_gap();
        res.ready <= (press_left == 0);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_BG_RED:       bg_r = val[7:0];
      CFG_BG_GREEN:     bg_g = val[7:0];
      CFG_BG_BLUE:      bg_b = val[7:0];
      CFG_FRAME_WIDTH:  width_reg = val;
      CFG_FRAME_HEIGHT: height_reg = val;
      CFG_RED_LIMIT:    hot_limit = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [10:0] w, input logic [10:0] h, input logic [7:0] r,
                          input logic [7:0] g, input logic [7:0] b, input logic [7:0] lim);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_BG_RED, {3'b0, r});
    write_reg(CFG_BG_GREEN, {3'b0, g});
    write_reg(CFG_BG_BLUE, {3'b0, b});
    write_reg(CFG_RED_LIMIT, {3'b0, lim});
    cfg_we <= 1'b0;
  endtask

  task automatic push_px(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pixel_q.insert(pixel_q.size(), {r, g, b});
    pixels_queued++;
  endtask

  // Background-heavy mix with colours one bit off and reds around the limit
  task automatic push_random(input int n);
    logic [23:0] c;
    repeat (n) begin
      c = {bg_r, bg_g, bg_b};
      case ($urandom_range(0, 9))
        0, 1, 2, 3: ;
        4:       c = 24'($urandom);
        5:       c[$urandom_range(0, 23)] ^= 1'b1;
        6:       c[23:16] = 8'd255;
        7:       c[23:16] = 8'd0;
        8:       c[23:16] = hot_limit;
        default: c[23:16] = hot_limit + 8'd1;
      endcase
      push_px(c[23:16], c[15:8], c[7:0]);
    end
  endtask

  // Idle: nothing queued or offered and no frame statistics outstanding
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pixel_q.size() != 0 || pix.valid || stats_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
    #1;
  endtask

  initial begin
    int unsigned w, h, frames, extra;
    logic [10:0] wr, hr;
    errors = 0; pixels_queued = 0; cycles = 0; calm = 0; press_go = 0; press_left = 0;
    cfg_we = 0; cfg_index = CFG_BG_RED; cfg_data = '0;
    pix.valid = 0; pix.red = 0; pix.green = 0; pix.blue = 0; res.ready = 0;
    col = 0; row = 0; hot_window = '0; fg_centre = 0;
    foreach (hot_rows[i, j]) hot_rows[i][j] = 0;
    foreach (fg_prev_row[i]) fg_prev_row[i] = 0;
    clear_sums();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Sizes below the minimum clamp to 2x2; black background, any red is hot
    set_regs(11'd0, 11'd1, 8'd0, 8'd0, 8'd0, 8'd0);
    repeat (4) push_px(8'd0, 8'd0, 8'd0);           // empty frame, no region
    repeat (4) push_px(8'd255, 8'd255, 8'd255);     // all foreground
    push_px(8'd0, 8'd0, 8'd1); push_px(8'd0, 8'd0, 8'd0);
    push_px(8'd0, 8'd0, 8'd0); push_px(8'd0, 8'd0, 8'd0);
    drain();

    // White background at the top red limit: nothing is ever hot
    set_regs(11'd3, 11'd3, 8'd255, 8'd255, 8'd255, 8'd255);
    push_px(8'd255, 8'd255, 8'd255); push_px(8'd255, 8'd255, 8'd254);
    push_px(8'd254, 8'd255, 8'd255); push_px(8'd255, 8'd254, 8'd255);
    push_px(8'd1, 8'd2, 8'd3);       push_px(8'd128, 8'd64, 8'd32);
    push_px(8'd255, 8'd255, 8'd255); push_px(8'd0, 8'd0, 8'd0);
    push_px(8'd255, 8'd255, 8'd255);
    drain();

    // Oversize width clamps: one full widest row, then the frame is cut short
    // by the smaller size written next
    set_regs(11'd2047, 11'd0, 8'd255, 8'd255, 8'd255, 8'd210);
    push_random(MAX_W + 8);
    drain();

    // Input backs up while the result side holds off
    set_regs(11'd2, 11'd2, 8'($urandom), 8'($urandom), 8'($urandom), 8'd128);
    press_go <= 1'b1;
    @(posedge clk);
    press_go <= 1'b0;
    push_random(4 * 30);
    drain();

    // Random frames; a trailing partial frame is finished under the next size
    while (pixels_queued < ITEM_GOAL) begin
      calm = ($urandom_range(0, 5) == 0);
      wr = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 40)) : 11'($urandom_range(2, 8));
      hr = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 12)) : 11'($urandom_range(2, 8));
      if ($urandom_range(0, 3) == 0)
        set_regs(wr, hr, 8'd255, 8'd255, 8'd255, 8'($urandom_range(0, 1) * 255));
      else
        set_regs(wr, hr, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      w = clamp_dim(wr, MAX_W);
      h = clamp_dim(hr, MAX_H);
      frames = $urandom_range(1, 4);
      extra = ($urandom_range(0, 9) == 0) ? $urandom_range(1, w * h - 1) : 0;
      push_random(frames * w * h + extra);
      drain();
    end

    calm = 0;
    drain();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
